[src/s2c_pkg.sv]
// shared constants, types and tables of the spherical to cartesian converter
package s2c_pkg;

    // number formats of the channels
    localparam int FRAC_BITS     = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int LON_W         = 26;
    localparam int LAT_W         = 24;
    localparam int OUT_W         = FRAC_BITS + 2;
    localparam int DEG_W         = LON_W;

    // binary angle (2^32 units per turn) and cordic word formats
    localparam int ANG_W   = 32;
    localparam int VEC_Q   = 30;
    localparam int XW      = 33;
    localparam int ZW      = 34;
    localparam int TRIG_W  = 32;
    localparam int PROD_W  = 2 * TRIG_W;

    // colatitude is this offset minus the latitude
    localparam logic signed [DEG_W-1:0] COLAT_OFFSET = DEG_W'(90 * (1 << FRAC_BITS));

    // cordic start vector: the gain 0.60725293500888 in Q30
    localparam logic signed [XW-1:0] GAIN_Q30 = XW'(652032874);

    // output clamp
    localparam logic signed [OUT_W-1:0] OUT_LIM = OUT_W'(1 << FRAC_BITS);

    typedef logic signed [TRIG_W-1:0] t_trig;
    typedef logic        [ANG_W-1:0]  t_angle;
    typedef logic signed [OUT_W-1:0]  t_coord;

    // atan(2^-i) as a binary angle
    localparam logic [ANG_W-1:0] ATAN_BAM [32] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
        32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
        32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
    };

    // clamp a rounded value to [-1, 1]
    function automatic t_coord sat_coord(input logic signed [PROD_W-1:0] v);
        t_coord res;
        if (v > PROD_W'(OUT_LIM)) begin
            res = OUT_LIM;
        end else if (v < -PROD_W'(OUT_LIM)) begin
            res = -OUT_LIM;
        end else begin
            res = v[OUT_W-1:0];
        end
        return res;
    endfunction

endpackage

[src/s2c_if.sv]
// valid/ready channel interfaces of the spherical to cartesian converter

// input channel: one point in degrees
interface s2c_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [s2c_pkg::LON_W-1:0]     lon_deg;
    logic signed [s2c_pkg::LAT_W-1:0]     lat_deg;

    modport source (output valid, output lon_deg, output lat_deg, input ready);
    modport sink   (input valid, input lon_deg, input lat_deg, output ready);
endinterface

// output channel: one point on the unit sphere
interface s2c_out_if;
    logic                valid;
    logic                ready;
    s2c_pkg::t_coord     x_coord;
    s2c_pkg::t_coord     y_coord;
    s2c_pkg::t_coord     z_coord;

    modport source (output valid, output x_coord, output y_coord, output z_coord, input ready);
    modport sink   (input valid, input x_coord, input y_coord, input z_coord, output ready);
endinterface

[src/s2c_bam.sv]
// pipelined conversion of a signed degree value to a 32-bit binary angle
module s2c_bam (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [s2c_pkg::DEG_W-1:0]    i_deg,
    output s2c_pkg::t_angle                     o_bam
);

    localparam int MAG_W  = s2c_pkg::DEG_W;
    localparam int SHIFT  = s2c_pkg::ANG_W - s2c_pkg::FRAC_BITS;
    // reciprocal of 360 for the magnitude split
    localparam int K1     = MAG_W + 9;
    localparam int M1_W   = K1 - 8;
    localparam int P1_W   = MAG_W + M1_W;
    localparam int A_W    = MAG_W - 8;
    localparam logic [M1_W-1:0] M1 = M1_W'((64'd1 << K1) / 64'd360);
    // remainder scaled by 2^SHIFT / 4, plus half of 90
    localparam int U_LO   = SHIFT - 2;
    localparam int U_W    = 9 + U_LO;
    localparam int K2     = U_W + 7;
    localparam int M2_W   = K2 - 6;
    localparam int P2_W   = U_W + M2_W;
    localparam int R_W    = P2_W - K2;
    localparam logic [M2_W-1:0] M2 = M2_W'((64'd1 << K2) / 64'd90);

    // stage 1: sign and magnitude
    logic             r_neg1;
    logic [MAG_W-1:0] r_mag1;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg1 <= i_deg[MAG_W-1];
            r_mag1 <= i_deg[MAG_W-1] ? MAG_W'(-i_deg) : MAG_W'(i_deg);
        end
    end

    // stage 2: estimate of magnitude / 360 by reciprocal
    logic             r_neg2;
    logic [MAG_W-1:0] r_mag2;
    logic [P1_W-1:0]  r_prod2;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg2  <= r_neg1;
            r_mag2  <= r_mag1;
            r_prod2 <= P1_W'(r_mag1) * P1_W'(M1);
        end
    end

    // stage 3: quotient estimate and its remainder
    logic [A_W-1:0] w_a_est;
    logic           r_neg3;
    logic [A_W-1:0] r_a3;
    logic [9:0]     r_b3;
    assign w_a_est = r_prod2[P1_W-1:K1];
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg3 <= r_neg2;
            r_a3   <= w_a_est;
            r_b3   <= 10'((MAG_W + 1)'(r_mag2) - (MAG_W + 1)'(w_a_est) * (MAG_W + 1)'(360));
        end
    end

    // stage 4: one correction step
    logic           r_neg4;
    logic [A_W-1:0] r_a4;
    logic [8:0]     r_b4;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg4 <= r_neg3;
            if (r_b3 >= 10'd360) begin
                r_a4 <= r_a3 + A_W'(1);
                r_b4 <= 9'(r_b3 - 10'd360);
            end else begin
                r_a4 <= r_a3;
                r_b4 <= r_b3[8:0];
            end
        end
    end

    // stage 5: rounded fraction of a turn, estimate of u / 90
    logic [U_W-1:0]  w_u;
    logic            r_neg5;
    logic [A_W-1:0]  r_a5;
    logic [U_W-1:0]  r_u5;
    logic [P2_W-1:0] r_prod5;
    assign w_u = {r_b4, U_LO'(45)};
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg5  <= r_neg4;
            r_a5    <= r_a4;
            r_u5    <= w_u;
            r_prod5 <= P2_W'(w_u) * P2_W'(M2);
        end
    end

    // stage 6: fraction estimate and its remainder
    logic [R_W-1:0] w_r_est;
    logic           r_neg6;
    logic [A_W-1:0] r_a6;
    logic [R_W-1:0] r_r6;
    logic [7:0]     r_rem6;
    assign w_r_est = r_prod5[P2_W-1:K2];
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg6 <= r_neg5;
            r_a6   <= r_a5;
            r_r6   <= w_r_est;
            r_rem6 <= 8'((U_W + 1)'(r_u5) - (U_W + 1)'(w_r_est) * (U_W + 1)'(90));
        end
    end

    // stage 7: correction, assemble turns and fraction, apply sign
    logic [SHIFT-1:0]           w_frac;
    logic [s2c_pkg::ANG_W-1:0]  w_q;
    s2c_pkg::t_angle            r_bam;
    assign w_frac = (r_rem6 >= 8'd90) ? SHIFT'(r_r6 + R_W'(1)) : SHIFT'(r_r6);
    assign w_q    = {r_a6[s2c_pkg::FRAC_BITS-1:0], w_frac};
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_bam <= r_neg6 ? -w_q : w_q;
        end
    end

    assign o_bam = r_bam;

endmodule

[src/s2c_cordic.sv]
// pipelined rotation-mode cordic giving cosine and sine in Q30
module s2c_cordic #(
    parameter int STAGES = s2c_pkg::CORDIC_STAGES
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  s2c_pkg::t_angle  i_bam,
    output s2c_pkg::t_trig   o_cos,
    output s2c_pkg::t_trig   o_sin
);

    localparam int XW = s2c_pkg::XW;
    localparam int ZW = s2c_pkg::ZW;
    localparam int AW = s2c_pkg::ANG_W;

    logic signed [XW-1:0] r_x [STAGES+1];
    logic signed [XW-1:0] r_y [STAGES+1];
    logic signed [ZW-1:0] r_z [STAGES];
    logic [STAGES:0]      r_flip;

    // fold angles in [90, 270) degrees by a half turn
    logic [AW-1:0] w_sum;
    logic          w_flip;
    logic [AW-1:0] w_fold;
    assign w_sum  = i_bam + AW'(32'h4000_0000);
    assign w_flip = w_sum[AW-1];
    assign w_fold = {i_bam[AW-1] ^ w_flip, i_bam[AW-2:0]};

    // fold register, then one micro-rotation per stage
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= s2c_pkg::GAIN_Q30;
            r_y[0]    <= '0;
            r_z[0]    <= ZW'($signed(w_fold));
            r_flip[0] <= w_flip;
            for (int k = 0; k < STAGES; k++) begin
                r_flip[k+1] <= r_flip[k];
                if (!r_z[k][ZW-1]) begin
                    r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                end else begin
                    r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                end
            end
            // angle residue, none is kept after the last rotation
            for (int k = 0; k < STAGES - 1; k++) begin
                if (!r_z[k][ZW-1]) begin
                    r_z[k+1] <= r_z[k] - $signed(ZW'(s2c_pkg::ATAN_BAM[k]));
                end else begin
                    r_z[k+1] <= r_z[k] + $signed(ZW'(s2c_pkg::ATAN_BAM[k]));
                end
            end
        end
    end

    // undo the fold
    s2c_pkg::t_trig r_cos;
    s2c_pkg::t_trig r_sin;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos <= s2c_pkg::TRIG_W'(r_flip[STAGES] ? -r_x[STAGES] : r_x[STAGES]);
            r_sin <= s2c_pkg::TRIG_W'(r_flip[STAGES] ? -r_y[STAGES] : r_y[STAGES]);
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

[src/spherical_to_cartesian_unit_top.sv]
// top level of the spherical to cartesian converter
//
// Converts a longitude and latitude in degrees (signed, 16 fraction bits) to
// the point x, y, z on the unit sphere (signed, 16 fraction bits, clamped to
// [-1, 1]). Input transactions arrive on i_in, results leave on o_out, both
// valid/ready channels; a transaction completes when valid and ready are high
// at a rising edge of i_clk.
// One result leaves for every input transaction, in order.
// The pipeline has one input register, seven stages of degree to binary angle
// conversion, a fold stage, one stage per cordic micro-rotation, an unfold
// stage, the products and the rounding stage that is also the output register.
// Throughput is one transaction per cycle unless the output stalls; the two
// cordic pipelines work side by side, one for longitude, one for colatitude.
// When o_out.ready is low with a result waiting, the whole pipeline holds and
// i_in.ready drops in the same cycle; nothing is lost or repeated.
// The synchronous active-low i_rst_n clears all valid bits; the block keeps
// no other state and accepts a transaction in the first cycle after reset.
module spherical_to_cartesian_unit_top #(
    parameter int CORDIC_STAGES = s2c_pkg::CORDIC_STAGES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    s2c_in_if.sink     i_in,
    s2c_out_if.source  o_out
);

    localparam int LAT      = CORDIC_STAGES + 12;
    localparam int DEG_W    = s2c_pkg::DEG_W;
    localparam int PROD_W   = s2c_pkg::PROD_W;
    localparam int XY_SH    = 2 * s2c_pkg::VEC_Q - s2c_pkg::FRAC_BITS;
    localparam int Z_SH     = s2c_pkg::VEC_Q - s2c_pkg::FRAC_BITS;

    logic           w_en;
    logic [LAT-1:0] r_vld;

    // pipeline advances unless a result is stalled at the output
    assign w_en       = !r_vld[LAT-1] || o_out.ready;
    assign i_in.ready = w_en;

    // valid bits travel alongside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_in.valid && w_en};
        end
    end

    // input register: longitude and colatitude
    logic signed [DEG_W-1:0] r_lon0;
    logic signed [DEG_W-1:0] r_colat0;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lon0   <= DEG_W'(i_in.lon_deg);
            r_colat0 <= s2c_pkg::COLAT_OFFSET - DEG_W'(i_in.lat_deg);
        end
    end

    // degree to binary angle
    s2c_pkg::t_angle w_lon_bam;
    s2c_pkg::t_angle w_colat_bam;

    s2c_bam u_lon_bam (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_deg (r_lon0),
        .o_bam (w_lon_bam)
    );

    s2c_bam u_colat_bam (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_deg (r_colat0),
        .o_bam (w_colat_bam)
    );

    // sine and cosine of both angles
    s2c_pkg::t_trig w_cl;
    s2c_pkg::t_trig w_sl;
    s2c_pkg::t_trig w_cc;
    s2c_pkg::t_trig w_sc;

    s2c_cordic #(.STAGES(CORDIC_STAGES)) u_lon_cordic (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_bam (w_lon_bam),
        .o_cos (w_cl),
        .o_sin (w_sl)
    );

    s2c_cordic #(.STAGES(CORDIC_STAGES)) u_colat_cordic (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_bam (w_colat_bam),
        .o_cos (w_cc),
        .o_sin (w_sc)
    );

    // products in Q60
    logic signed [PROD_W-1:0] r_px;
    logic signed [PROD_W-1:0] r_py;
    s2c_pkg::t_trig           r_cz;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_px <= PROD_W'(w_cl) * PROD_W'(w_sc);
            r_py <= PROD_W'(w_sl) * PROD_W'(w_sc);
            r_cz <= w_cc;
        end
    end

    // round half up, clamp, output register
    logic signed [PROD_W-1:0] w_xr;
    logic signed [PROD_W-1:0] w_yr;
    logic signed [PROD_W-1:0] w_zr;
    assign w_xr = (r_px + (PROD_W'(1) <<< (XY_SH - 1))) >>> XY_SH;
    assign w_yr = (r_py + (PROD_W'(1) <<< (XY_SH - 1))) >>> XY_SH;
    assign w_zr = (PROD_W'(r_cz) + (PROD_W'(1) <<< (Z_SH - 1))) >>> Z_SH;

    s2c_pkg::t_coord r_x;
    s2c_pkg::t_coord r_y;
    s2c_pkg::t_coord r_z;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x <= s2c_pkg::sat_coord(w_xr);
            r_y <= s2c_pkg::sat_coord(w_yr);
            r_z <= s2c_pkg::sat_coord(w_zr);
        end
    end

    assign o_out.valid   = r_vld[LAT-1];
    assign o_out.x_coord = r_x;
    assign o_out.y_coord = r_y;
    assign o_out.z_coord = r_z;

endmodule

[src/s2c_checker.sv]
// port-level checks of the spherical to cartesian converter and their binding
module s2c_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_ready,
    input  logic            i_out_valid,
    input  logic            i_out_ready,
    input  s2c_pkg::t_coord i_x,
    input  s2c_pkg::t_coord i_y,
    input  s2c_pkg::t_coord i_z
);

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_x) && $stable(i_y) && $stable(i_z))
        else $error("stalled result changed or vanished");

    // with the output empty the input is never refused
    a_in_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input refused while output empty");

    // a stalled output stops the input side in the same cycle
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("input accepted while output stalled");

    // every coordinate lies on [-1, 1]
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            (i_x >= -s2c_pkg::OUT_LIM) && (i_x <= s2c_pkg::OUT_LIM) &&
            (i_y >= -s2c_pkg::OUT_LIM) && (i_y <= s2c_pkg::OUT_LIM) &&
            (i_z >= -s2c_pkg::OUT_LIM) && (i_z <= s2c_pkg::OUT_LIM))
        else $error("coordinate out of range");

endmodule

bind spherical_to_cartesian_unit_top s2c_checker u_s2c_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_x         (o_out.x_coord),
    .i_y         (o_out.y_coord),
    .i_z         (o_out.z_coord)
);
